// ----- src/jmsp_pkg.sv -----
package jmsp_pkg;

  localparam int QUANT_ENTRIES_DEF = 64;
  localparam int HUFF_LENGTHS_DEF  = 16;
  localparam int QUANT_TABLES_DEF  = 4;

  // result kinds
  localparam logic [3:0] K_QENTRY     = 4'd0;
  localparam logic [3:0] K_HCOUNT     = 4'd1;
  localparam logic [3:0] K_HSYMBOL    = 4'd2;
  localparam logic [3:0] K_HEIGHT     = 4'd3;
  localparam logic [3:0] K_WIDTH      = 4'd4;
  localparam logic [3:0] K_CHANNELS   = 4'd5;
  localparam logic [3:0] K_SCANCOMP   = 4'd6;
  localparam logic [3:0] K_SCANPARAMS = 4'd7;
  localparam logic [3:0] K_DATA       = 4'd8;
  localparam logic [3:0] K_EOI        = 4'd9;
  localparam logic [3:0] K_BADSTART   = 4'd10;
  localparam logic [3:0] K_BADQID     = 4'd11;

  // marker codes
  localparam logic [7:0] MK_FF  = 8'hFF;
  localparam logic [7:0] MK_SOI = 8'hD8;
  localparam logic [7:0] MK_EOI = 8'hD9;
  localparam logic [7:0] MK_DQT = 8'hDB;
  localparam logic [7:0] MK_DHT = 8'hC4;
  localparam logic [7:0] MK_SOS = 8'hDA;
  localparam logic [7:0] MK_SOF0 = 8'hC0;
  localparam logic [7:0] MK_SOF2 = 8'hC2;
  localparam logic [7:0] MK_RST0 = 8'hD0;
  localparam logic [7:0] MK_RST7 = 8'hD7;
  localparam logic [7:0] MK_APP0 = 8'hE0;
  localparam logic [7:0] MK_APP15 = 8'hEF;

  // byte classes from the front end
  localparam logic [2:0] C_OTHER = 3'd0;
  localparam logic [2:0] C_FF    = 3'd1;
  localparam logic [2:0] C_ZERO  = 3'd2;
  localparam logic [2:0] C_RST   = 3'd3;
  localparam logic [2:0] C_APP   = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [2:0] cls;
  } tok_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [3:0]  table_class;
    logic [3:0]  table_id;
    logic [3:0]  precision;
    logic [11:0] index;
    logic [15:0] value;
    logic [3:0]  sel_high;
    logic [3:0]  sel_low;
  } res_t;

endpackage

// ----- src/jmsp_if.sv -----
interface jmsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface jmsp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  kind;
  logic [3:0]  table_class;
  logic [3:0]  table_id;
  logic [3:0]  precision;
  logic [11:0] index;
  logic [15:0] value;
  logic [3:0]  sel_high;
  logic [3:0]  sel_low;
  modport source (output valid, output kind, output table_class, output table_id,
                  output precision, output index, output value, output sel_high,
                  output sel_low, input ready);
  modport sink (input valid, input kind, input table_class, input table_id,
                input precision, input index, input value, input sel_high,
                input sel_low, output ready);
endinterface

// ----- src/jpeg_marker_stream_parser.sv -----
// path: an accepted byte goes into the queue, then its result into the result register
// throughput: one byte per cycle when results flow, set by the single-step parse state update
// reset: synchronous rst returns to waiting for the FF D8 start pair and clears the
// queue, the result register and the halted flag
module jpeg_marker_stream_parser #(
  parameter int QUANT_ENTRIES = jmsp_pkg::QUANT_ENTRIES_DEF,
  parameter int HUFF_LENGTHS  = jmsp_pkg::HUFF_LENGTHS_DEF,
  parameter int QUANT_TABLES  = jmsp_pkg::QUANT_TABLES_DEF
) (
  input logic      clk,
  input logic      rst,
  jmsp_in_if.sink  in_ch,
  jmsp_out_if.source out_ch
);
  // front: classify each byte (FF, 00, restart, app marker) into a short queue
  logic           tok_valid;
  logic           tok_ready;
  jmsp_pkg::tok_t tok;
  jmsp_pkg::res_t res;

  jmsp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_byte   (in_ch.data_byte),
    .in_ready  (in_ch.ready),
    .tok_valid (tok_valid),
    .tok       (tok),
    .tok_ready (tok_ready)
  );

  // back: segment state machine, one queued item per cycle unless stalled, into result register
  jmsp_back #(
    .QUANT_ENTRIES (QUANT_ENTRIES),
    .HUFF_LENGTHS  (HUFF_LENGTHS),
    .QUANT_TABLES  (QUANT_TABLES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (tok_valid),
    .tok       (tok),
    .tok_ready (tok_ready),
    .res_valid (out_ch.valid),
    .res       (res),
    .res_ready (out_ch.ready)
  );

  assign out_ch.kind        = res.kind;
  assign out_ch.table_class = res.table_class;
  assign out_ch.table_id    = res.table_id;
  assign out_ch.precision   = res.precision;
  assign out_ch.index       = res.index;
  assign out_ch.value       = res.value;
  assign out_ch.sel_high    = res.sel_high;
  assign out_ch.sel_low     = res.sel_low;

  // a result kind never falls outside the defined codes
  assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.kind <= jmsp_pkg::K_BADQID)
    else $error("bad result kind");

  // a stalled result holds its kind
  assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.kind))
    else $error("stalled result changed");

  // after a halt reporting error nothing more comes out
  assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.ready &&
    (out_ch.kind == jmsp_pkg::K_BADSTART || out_ch.kind == jmsp_pkg::K_BADQID)
    |=> !out_ch.valid)
    else $error("result after halt");
endmodule

// ----- src/jmsp_front.sv -----
module jmsp_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [7:0]         in_byte,
  output logic               in_ready,
  output logic               tok_valid,
  output jmsp_pkg::tok_t     tok,
  input  logic               tok_ready
);
  // two-entry queue of classified bytes
  jmsp_pkg::tok_t q [2];
  logic           rd_ptr;
  logic           wr_ptr;
  logic [1:0]     count;
  jmsp_pkg::tok_t cls_tok;
  logic           push;
  logic           pop;

  always_comb begin
    cls_tok.data_byte = in_byte;
    if (in_byte == jmsp_pkg::MK_FF) cls_tok.cls = jmsp_pkg::C_FF;
    else if (in_byte == 8'h00) cls_tok.cls = jmsp_pkg::C_ZERO;
    else if (in_byte inside {[jmsp_pkg::MK_RST0:jmsp_pkg::MK_RST7]})
      cls_tok.cls = jmsp_pkg::C_RST;
    else if (in_byte inside {[jmsp_pkg::MK_APP0:jmsp_pkg::MK_APP15]})
      cls_tok.cls = jmsp_pkg::C_APP;
    else cls_tok.cls = jmsp_pkg::C_OTHER;
  end

  assign in_ready  = (count != 2'd2);
  assign push      = in_valid && in_ready;
  assign tok_valid = (count != 2'd0);
  assign pop       = tok_valid && tok_ready;
  assign tok       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= cls_tok;
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ----- src/jmsp_back.sv -----
module jmsp_back #(
  parameter int QUANT_ENTRIES = jmsp_pkg::QUANT_ENTRIES_DEF,
  parameter int HUFF_LENGTHS  = jmsp_pkg::HUFF_LENGTHS_DEF,
  parameter int QUANT_TABLES  = jmsp_pkg::QUANT_TABLES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           tok_valid,
  input  jmsp_pkg::tok_t tok,
  output logic           tok_ready,
  output logic           res_valid,
  output jmsp_pkg::res_t res,
  input  logic           res_ready
);
  localparam logic [5:0] S_START1 = 6'd0,  S_START2 = 6'd1,  S_HUNT = 6'd2,
                         S_MARKER = 6'd3,  S_SOF_LH = 6'd4,  S_SOF_LL = 6'd5,
                         S_DQT_LH = 6'd6,  S_DQT_LL = 6'd7,  S_DHT_LH = 6'd8,
                         S_DHT_LL = 6'd9,  S_SOS_LH = 6'd10, S_SOS_LL = 6'd11,
                         S_APP_LH = 6'd12, S_APP_LL = 6'd13, S_SOF_PREC = 6'd14,
                         S_SOF_H1 = 6'd15, S_SOF_H2 = 6'd16, S_SOF_W1 = 6'd17,
                         S_SOF_W2 = 6'd18, S_SOF_CH = 6'd19, S_SKIP = 6'd20,
                         S_DQT_INFO = 6'd21, S_DQT_ENT = 6'd22, S_DHT_INFO = 6'd23,
                         S_DHT_CNT = 6'd24, S_DHT_SYM = 6'd25, S_SOS_NC = 6'd26,
                         S_SOS_CID = 6'd27, S_SOS_CTAB = 6'd28, S_SOS_SS = 6'd29,
                         S_SOS_SE = 6'd30, S_SOS_AH = 6'd31, S_ECS = 6'd32,
                         S_ECS_FF = 6'd33;
  localparam logic [11:0] QE  = 12'(QUANT_ENTRIES);
  localparam logic [11:0] QE2 = 12'(2 * QUANT_ENTRIES);
  localparam logic [11:0] HL  = 12'(HUFF_LENGTHS);
  localparam logic [4:0]  QT  = 5'(QUANT_TABLES);

  logic [5:0]  mode, mode_next;
  logic [15:0] segment_left, segment_left_next;
  logic [11:0] field_count, field_count_next;
  logic [7:0]  held_byte, held_byte_next;
  logic [11:0] current_table, current_table_next;
  logic [11:0] symbol_total, symbol_total_next;
  logic [7:0]  component_total, component_total_next;
  logic        halted, halted_next;

  logic           emit;
  jmsp_pkg::res_t r;
  logic [7:0]     b;
  logic [2:0]     c;
  logic [15:0]    len;
  logic [15:0]    seg_dec;
  logic [11:0]    fc_inc;
  logic [11:0]    st_sum;
  logic [15:0]    len_m2;
  logic [15:0]    len_m8;
  logic           take;

  // output register; accepts a new result while the old one is being taken
  assign tok_ready = !res_valid || res_ready;
  assign take      = tok_valid && tok_ready;

  assign b       = tok.data_byte;
  assign c       = tok.cls;
  assign len     = {held_byte, b};
  assign seg_dec = (segment_left != 16'd0) ? segment_left - 16'd1 : 16'd0;
  assign fc_inc  = field_count + 12'd1;
  assign st_sum  = symbol_total + {4'd0, b};
  assign len_m2  = (len >= 16'd2) ? len - 16'd2 : 16'd0;
  assign len_m8  = (len >= 16'd8) ? len - 16'd8 : 16'd0;

  always_comb begin
    mode_next = mode;
    segment_left_next = segment_left;
    field_count_next = field_count;
    held_byte_next = held_byte;
    current_table_next = current_table;
    symbol_total_next = symbol_total;
    component_total_next = component_total;
    halted_next = halted;
    emit = 1'b0;
    r = '0;
    if (!halted) begin
      case (mode)
        S_START1, S_START2: begin
          if (b != ((mode == S_START1) ? jmsp_pkg::MK_FF : jmsp_pkg::MK_SOI)) begin
            halted_next = 1'b1;
            emit = 1'b1;
            r.kind = jmsp_pkg::K_BADSTART;
            r.value = {8'd0, b};
          end else begin
            mode_next = (mode == S_START1) ? S_START2 : S_HUNT;
          end
        end
        S_HUNT: if (c == jmsp_pkg::C_FF) mode_next = S_MARKER;
        S_SOF_LH, S_DQT_LH, S_DHT_LH, S_SOS_LH, S_APP_LH, S_SOF_H1, S_SOF_W1: begin
          held_byte_next = b;
          mode_next = mode + 6'd1;
        end
        S_SOF_LL: begin
          segment_left_next = len_m8;
          mode_next = S_SOF_PREC;
        end
        S_DQT_LL, S_DHT_LL: begin
          segment_left_next = len_m2;
          if (len_m2 == 16'd0) mode_next = S_HUNT;
          else mode_next = (mode == S_DQT_LL) ? S_DQT_INFO : S_DHT_INFO;
        end
        S_SOS_LL: mode_next = S_SOS_NC;
        S_APP_LL: begin
          segment_left_next = len_m2;
          mode_next = (len_m2 == 16'd0) ? S_HUNT : S_SKIP;
        end
        S_SOF_PREC: mode_next = S_SOF_H1;
        S_SOF_H2: begin
          mode_next = S_SOF_W1;
          emit = 1'b1;
          r.kind = jmsp_pkg::K_HEIGHT;
          r.value = len;
        end
        S_SOF_W2: begin
          mode_next = S_SOF_CH;
          emit = 1'b1;
          r.kind = jmsp_pkg::K_WIDTH;
          r.value = len;
        end
        S_SOF_CH: begin
          mode_next = (segment_left == 16'd0) ? S_HUNT : S_SKIP;
          emit = 1'b1;
          r.kind = jmsp_pkg::K_CHANNELS;
          r.value = {8'd0, b};
        end
        S_SKIP: begin
          segment_left_next = seg_dec;
          if (seg_dec == 16'd0) mode_next = S_HUNT;
        end
        S_DQT_INFO: begin
          segment_left_next = seg_dec;
          if ({1'b0, b[3:0]} >= QT) begin
            halted_next = 1'b1;
            emit = 1'b1;
            r.kind = jmsp_pkg::K_BADQID;
            r.table_id = b[3:0];
            r.precision = b[7:4];
          end else begin
            current_table_next = {4'd0, b};
            field_count_next = 12'd0;
            mode_next = S_DQT_ENT;
          end
        end
        S_DQT_ENT: begin
          segment_left_next = seg_dec;
          field_count_next = fc_inc;
          r.kind = jmsp_pkg::K_QENTRY;
          r.table_id = current_table[3:0];
          if (current_table[7:4] == 4'd0) begin
            emit = 1'b1;
            r.index = field_count;
            r.value = {8'd0, b};
            if (fc_inc >= QE) mode_next = (seg_dec == 16'd0) ? S_HUNT : S_DQT_INFO;
          end else begin
            if (!field_count[0]) begin
              held_byte_next = b;
            end else begin
              emit = 1'b1;
              r.precision = current_table[7:4];
              r.index = field_count >> 1;
              r.value = len;
            end
            if (fc_inc >= QE2) mode_next = (seg_dec == 16'd0) ? S_HUNT : S_DQT_INFO;
          end
        end
        S_DHT_INFO: begin
          segment_left_next = seg_dec;
          current_table_next = {4'd0, b};
          field_count_next = 12'd0;
          symbol_total_next = 12'd0;
          mode_next = S_DHT_CNT;
        end
        S_DHT_CNT: begin
          segment_left_next = seg_dec;
          symbol_total_next = st_sum;
          emit = 1'b1;
          r.kind = jmsp_pkg::K_HCOUNT;
          r.table_class = current_table[7:4];
          r.table_id = current_table[3:0];
          r.index = field_count;
          r.value = {8'd0, b};
          field_count_next = fc_inc;
          if (fc_inc >= HL) begin
            field_count_next = 12'd0;
            if (st_sum != 12'd0) mode_next = S_DHT_SYM;
            else mode_next = (seg_dec == 16'd0) ? S_HUNT : S_DHT_INFO;
          end
        end
        S_DHT_SYM: begin
          segment_left_next = seg_dec;
          emit = 1'b1;
          r.kind = jmsp_pkg::K_HSYMBOL;
          r.table_class = current_table[7:4];
          r.table_id = current_table[3:0];
          r.index = field_count;
          r.value = {8'd0, b};
          field_count_next = fc_inc;
          if (fc_inc >= symbol_total) mode_next = (seg_dec == 16'd0) ? S_HUNT : S_DHT_INFO;
        end
        S_SOS_NC: begin
          component_total_next = b;
          field_count_next = 12'd0;
          mode_next = (b == 8'd0) ? S_SOS_SS : S_SOS_CID;
        end
        S_SOS_CID: begin
          held_byte_next = b;
          mode_next = S_SOS_CTAB;
        end
        S_SOS_CTAB: begin
          emit = 1'b1;
          r.kind = jmsp_pkg::K_SCANCOMP;
          r.index = field_count;
          r.value = {8'd0, held_byte};
          r.sel_high = b[7:4];
          r.sel_low = b[3:0];
          field_count_next = fc_inc;
          mode_next = (fc_inc >= {4'd0, component_total}) ? S_SOS_SS : S_SOS_CID;
        end
        S_SOS_SS: begin
          current_table_next = {4'd0, b};
          mode_next = S_SOS_SE;
        end
        S_SOS_SE: begin
          held_byte_next = b;
          mode_next = S_SOS_AH;
        end
        S_SOS_AH: begin
          mode_next = S_ECS;
          emit = 1'b1;
          r.kind = jmsp_pkg::K_SCANPARAMS;
          r.index = current_table;
          r.value = {8'd0, held_byte};
          r.sel_high = b[7:4];
          r.sel_low = b[3:0];
        end
        S_ECS: begin
          if (c == jmsp_pkg::C_FF) begin
            mode_next = S_ECS_FF;
          end else begin
            emit = 1'b1;
            r.kind = jmsp_pkg::K_DATA;
            r.value = {8'd0, b};
          end
        end
        S_MARKER, S_ECS_FF: begin
          if (mode == S_ECS_FF && c == jmsp_pkg::C_ZERO) begin
            mode_next = S_ECS;
            emit = 1'b1;
            r.kind = jmsp_pkg::K_DATA;
            r.value = 16'h00FF;
          end else if (mode == S_ECS_FF && c == jmsp_pkg::C_RST) begin
            mode_next = S_ECS;
          end else if (b == jmsp_pkg::MK_SOF0 || b == jmsp_pkg::MK_SOF2) begin
            mode_next = S_SOF_LH;
          end else if (b == jmsp_pkg::MK_DQT) begin
            mode_next = S_DQT_LH;
          end else if (b == jmsp_pkg::MK_DHT) begin
            mode_next = S_DHT_LH;
          end else if (b == jmsp_pkg::MK_SOS) begin
            mode_next = S_SOS_LH;
          end else if (b == jmsp_pkg::MK_EOI) begin
            mode_next = S_HUNT;
            emit = 1'b1;
            r.kind = jmsp_pkg::K_EOI;
          end else if (c == jmsp_pkg::C_APP) begin
            mode_next = S_APP_LH;
          end else begin
            mode_next = S_HUNT;
          end
        end
        default: mode_next = S_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) res <= r;
    if (rst) begin
      mode <= S_START1;
      segment_left <= '0;
      field_count <= '0;
      held_byte <= '0;
      current_table <= '0;
      symbol_total <= '0;
      component_total <= '0;
      halted <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (take) begin
        mode <= mode_next;
        segment_left <= segment_left_next;
        field_count <= field_count_next;
        held_byte <= held_byte_next;
        current_table <= current_table_next;
        symbol_total <= symbol_total_next;
        component_total <= component_total_next;
        halted <= halted_next;
      end
      if (take) res_valid <= emit;
      else if (res_ready) res_valid <= 1'b0;
    end
  end
endmodule
